/* sv/psp_pkg.sv */
// psp_pkg: shared types and constants for the pivot-to-permutation core.
// Transaction payload structs and configuration register indexes.
// No dependencies.
package psp_pkg;

  localparam int PIVOT_W   = 7;
  localparam int ENTRY_W   = 6;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_MODE       = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_INDEX_BASE = 1'b1;

  typedef struct packed {
    logic [PIVOT_W-1:0] pivot;
    logic               final_req;
  } in_t;

  typedef struct packed {
    logic [ENTRY_W-1:0] position;
    logic [ENTRY_W-1:0] entry;
    logic               end_of_run;
    logic               bad_pivot;
  } out_t;

endpackage

/* sv/pivot_swaps_to_permutation_core.sv */
// pivot_swaps_to_permutation_core: top level of the pivot-to-permutation core.
// Instantiates psp_load, psp_perm and psp_ctrl; depends on psp_pkg.
//
// Usage:
//   Pivots arrive on request, one per transaction, taken at a clock edge with
//   start high and busy low. Busy stays low after a non-final pivot. A pivot
//   with final_req set starts a run and raises busy. A run of length L over
//   n held pivots is an identity fill of positions 0 to L-1, then, for each
//   swap, a pivot read, a two-port permutation read and two writes through
//   the single write port of the permutation store, then an emit pass; the
//   last result comes in the same cycle in which busy drops.
//   Results come on result, one per cycle, each marked by result_valid for one
//   cycle, positions 0 to L-1 in order, end_of_run on the last. The receiver
//   cannot stall them.
//   Configuration: cfg_we, cfg_index, cfg_data; write only while idle.
//   Reset (rst, synchronous) clears both registers, the pivot count, the
//   largest pivot and the error flag; the stores need no clearing.
module pivot_swaps_to_permutation_core import psp_pkg::*; #(
  parameter int MAX_LEN = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  in_t                  request,
  output logic                 result_valid,
  output out_t                 result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  localparam int AW = $clog2(MAX_LEN);
  localparam int CW = $clog2(MAX_LEN + 1);

  logic          mode, index_base;
  logic          accept;
  logic [AW-1:0] pivot_raddr, pivot_rdata;
  logic [CW-1:0] run_len, run_count;
  logic          run_err;
  logic          perm_we, perm_re;
  logic [AW-1:0] perm_waddr, perm_wdata, perm_raddr_a, perm_raddr_b;
  logic [AW-1:0] perm_rdata_a, perm_rdata_b;
  logic [AW-1:0] emit_pos;
  logic          emit_last, emit_err;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= 1'b0;
      index_base <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:       mode       <= cfg_data[0];
        REG_INDEX_BASE: index_base <= cfg_data[0];
        default:        mode       <= mode;
      endcase
    end
  end

  psp_load #(.MAX_LEN(MAX_LEN)) u_load (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .pivot      (request.pivot),
    .final_req  (request.final_req),
    .index_base (index_base),
    .raddr      (pivot_raddr),
    .rdata      (pivot_rdata),
    .run_len    (run_len),
    .run_count  (run_count),
    .run_err    (run_err)
  );

  psp_perm #(.MAX_LEN(MAX_LEN)) u_perm (
    .clk     (clk),
    .we      (perm_we),
    .waddr   (perm_waddr),
    .wdata   (perm_wdata),
    .re      (perm_re),
    .raddr_a (perm_raddr_a),
    .raddr_b (perm_raddr_b),
    .rdata_a (perm_rdata_a),
    .rdata_b (perm_rdata_b)
  );

  psp_ctrl #(.MAX_LEN(MAX_LEN)) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .final_req    (request.final_req),
    .mode         (mode),
    .run_len      (run_len),
    .run_count    (run_count),
    .run_err      (run_err),
    .busy         (busy),
    .pivot_raddr  (pivot_raddr),
    .pivot_rdata  (pivot_rdata),
    .perm_we      (perm_we),
    .perm_waddr   (perm_waddr),
    .perm_wdata   (perm_wdata),
    .perm_re      (perm_re),
    .perm_raddr_a (perm_raddr_a),
    .perm_raddr_b (perm_raddr_b),
    .perm_rdata_a (perm_rdata_a),
    .perm_rdata_b (perm_rdata_b),
    .emit_valid   (result_valid),
    .emit_pos     (emit_pos),
    .emit_last    (emit_last),
    .emit_err     (emit_err)
  );

  always_comb begin
    result.position   = ENTRY_W'(emit_pos);
    result.entry      = ENTRY_W'(perm_rdata_a);
    result.end_of_run = emit_last;
    result.bad_pivot  = emit_err;
  end

endmodule

/* sv/psp_load.sv */
// psp_load: pivot store and running pivot count, largest pivot and error flag.
// Presents the post-transaction run summary on a final pivot.
// Depends on psp_pkg.
module psp_load import psp_pkg::*; #(
  parameter int MAX_LEN = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic [PIVOT_W-1:0]           pivot,
  input  logic                         final_req,
  input  logic                         index_base,
  input  logic [$clog2(MAX_LEN)-1:0]   raddr,
  output logic [$clog2(MAX_LEN)-1:0]   rdata,
  output logic [$clog2(MAX_LEN+1)-1:0] run_len,
  output logic [$clog2(MAX_LEN+1)-1:0] run_count,
  output logic                         run_err
);

  localparam int AW = $clog2(MAX_LEN);
  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int EW = ((CW > PIVOT_W) ? CW : PIVOT_W) + 1;

  logic [AW-1:0] mem [MAX_LEN];

  logic [CW-1:0] count, count_next;
  logic [CW-1:0] largest, largest_next;
  logic          err, err_next;
  logic          has_room, in_range;
  logic [EW-1:0] j_ext;
  logic [AW-1:0] stored;

  always_comb begin
    has_room     = count < CW'(MAX_LEN);
    j_ext        = EW'(pivot) - EW'(index_base);
    in_range     = (pivot >= PIVOT_W'(index_base)) && (j_ext < EW'(MAX_LEN));
    stored       = in_range ? AW'(j_ext) : count[AW-1:0];
    count_next   = has_room ? count + CW'(1) : count;
    largest_next = largest;
    if (has_room && in_range && ((j_ext + EW'(1)) > EW'(largest))) begin
      largest_next = CW'(j_ext + EW'(1));
    end
    err_next  = err | ~has_room | ~in_range;
    run_count = count_next;
    run_len   = (largest_next > count_next) ? largest_next : count_next;
    run_err   = err_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      largest <= '0;
      err     <= 1'b0;
    end else if (accept) begin
      if (final_req) begin
        count   <= '0;
        largest <= '0;
        err     <= 1'b0;
      end else begin
        count   <= count_next;
        largest <= largest_next;
        err     <= err_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && has_room) begin
      mem[count[AW-1:0]] <= stored;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/psp_perm.sv */
// psp_perm: permutation store, one write port and two registered read ports.
// Read data holds while read enable is low.
// Depends on psp_pkg.
module psp_perm import psp_pkg::*; #(
  parameter int MAX_LEN = 64
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(MAX_LEN)-1:0] waddr,
  input  logic [$clog2(MAX_LEN)-1:0] wdata,
  input  logic                       re,
  input  logic [$clog2(MAX_LEN)-1:0] raddr_a,
  input  logic [$clog2(MAX_LEN)-1:0] raddr_b,
  output logic [$clog2(MAX_LEN)-1:0] rdata_a,
  output logic [$clog2(MAX_LEN)-1:0] rdata_b
);

  localparam int AW = $clog2(MAX_LEN);

  logic [AW-1:0] mem [MAX_LEN];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

/* sv/psp_ctrl.sv */
// psp_ctrl: run sequencer - identity fill, swap pass, emit pass.
// Drives the pivot store read port and the permutation store.
// Depends on psp_pkg.
module psp_ctrl import psp_pkg::*; #(
  parameter int MAX_LEN = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic                         final_req,
  input  logic                         mode,
  input  logic [$clog2(MAX_LEN+1)-1:0] run_len,
  input  logic [$clog2(MAX_LEN+1)-1:0] run_count,
  input  logic                         run_err,
  output logic                         busy,
  output logic [$clog2(MAX_LEN)-1:0]   pivot_raddr,
  input  logic [$clog2(MAX_LEN)-1:0]   pivot_rdata,
  output logic                         perm_we,
  output logic [$clog2(MAX_LEN)-1:0]   perm_waddr,
  output logic [$clog2(MAX_LEN)-1:0]   perm_wdata,
  output logic                         perm_re,
  output logic [$clog2(MAX_LEN)-1:0]   perm_raddr_a,
  output logic [$clog2(MAX_LEN)-1:0]   perm_raddr_b,
  input  logic [$clog2(MAX_LEN)-1:0]   perm_rdata_a,
  input  logic [$clog2(MAX_LEN)-1:0]   perm_rdata_b,
  output logic                         emit_valid,
  output logic [$clog2(MAX_LEN)-1:0]   emit_pos,
  output logic                         emit_last,
  output logic                         emit_err
);

  localparam int AW = $clog2(MAX_LEN);
  localparam int CW = $clog2(MAX_LEN + 1);

  typedef enum logic [2:0] {
    IDLE, FILL, SW_RDP, SW_RDQ, SW_WRA, SW_WRB, EMIT
  } state_t;

  state_t        state;
  logic [AW-1:0] cnt;
  logic [AW-1:0] swap_j;
  logic [CW-1:0] len;
  logic [CW-1:0] n;
  logic          rmode;
  logic          cnt_last, swap_last;

  always_comb begin
    cnt_last  = (CW'(cnt) + CW'(1)) == len;
    swap_last = rmode ? (cnt == '0) : ((CW'(cnt) + CW'(1)) == n);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      emit_valid <= 1'b0;
    end else begin
      emit_valid <= 1'b0;
      unique case (state)
        IDLE: begin
          if (accept && final_req) begin
            state    <= FILL;
            cnt      <= '0;
            len      <= run_len;
            n        <= run_count;
            emit_err <= run_err;
            rmode    <= mode;
          end
        end
        FILL: begin
          if (cnt_last) begin
            state <= SW_RDP;
            cnt   <= rmode ? AW'(n - CW'(1)) : '0;
          end else begin
            cnt <= cnt + AW'(1);
          end
        end
        SW_RDP: state <= SW_RDQ;
        SW_RDQ: begin
          swap_j <= pivot_rdata;
          state  <= SW_WRA;
        end
        SW_WRA: state <= SW_WRB;
        SW_WRB: begin
          if (swap_last) begin
            state <= EMIT;
            cnt   <= '0;
          end else begin
            state <= SW_RDP;
            cnt   <= rmode ? cnt - AW'(1) : cnt + AW'(1);
          end
        end
        EMIT: begin
          emit_valid <= 1'b1;
          emit_pos   <= cnt;
          emit_last  <= cnt_last;
          if (cnt_last) begin
            state <= IDLE;
          end else begin
            cnt <= cnt + AW'(1);
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  always_comb begin
    busy         = state != IDLE;
    pivot_raddr  = cnt;
    perm_re      = (state == SW_RDQ) || (state == EMIT);
    perm_raddr_a = cnt;
    perm_raddr_b = pivot_rdata;
    perm_we      = 1'b0;
    perm_waddr   = cnt;
    perm_wdata   = cnt;
    unique case (state)
      FILL: perm_we = 1'b1;
      SW_WRA: begin
        perm_we    = 1'b1;
        perm_wdata = perm_rdata_b;
      end
      SW_WRB: begin
        perm_we    = 1'b1;
        perm_waddr = swap_j;
        perm_wdata = perm_rdata_a;
      end
      default: perm_we = 1'b0;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_final_starts_fill: assert property (@(posedge clk) disable iff (rst)
    (state == IDLE && accept && final_req) |=> (state == FILL))
    else $error("final pivot did not start a run");

  a_no_write_in_emit: assert property (@(posedge clk) disable iff (rst)
    (state == EMIT) |-> !perm_we)
    else $error("permutation store written during emit");

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    (emit_valid && emit_last) |=> !emit_valid)
    else $error("result after end of run");

  a_swap_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == SW_WRB) |-> (CW'(swap_j) < len && CW'(cnt) < len))
    else $error("swap outside run length");
`endif

endmodule
